// ----- hw/rtl/i2crs_pkg.sv -----
// ----------------------------------------------------------------------------
// i2crs_pkg
// Shared types and constants of the I2C ranging sensor master.
// ----------------------------------------------------------------------------
package i2crs_pkg;

  localparam int unsigned HalfBitReset  = 10;
  localparam int unsigned AckPollReset  = 250;
  localparam int unsigned ReadSetupReset = 100;
  localparam int unsigned RangeWaitReset = 50000;
  localparam int unsigned CfgDataWidth  = 20;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [1:0] CFG_HALF_BIT   = 2'd0;
  localparam logic [1:0] CFG_ACK_POLL   = 2'd1;
  localparam logic [1:0] CFG_READ_SETUP = 2'd2;
  localparam logic [1:0] CFG_RANGE_WAIT = 2'd3;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_RANGE = 2'd3;

  localparam logic [1:0] MODE_RREAD = 2'd0;

  localparam logic [7:0] RangeRegHigh = 8'h02;
  localparam logic [7:0] RangeRegLow  = 8'h03;

  typedef enum logic [11:0] {
    IT_IDLE   = 12'b0000_0000_0001,
    IT_START  = 12'b0000_0000_0010,
    IT_SADDR  = 12'b0000_0000_0100,
    IT_SREG   = 12'b0000_0000_1000,
    IT_SDATA  = 12'b0000_0001_0000,
    IT_SRADDR = 12'b0000_0010_0000,
    IT_ACK    = 12'b0000_0100_0000,
    IT_STOP   = 12'b0000_1000_0000,
    IT_SETUP  = 12'b0001_0000_0000,
    IT_RWAIT  = 12'b0010_0000_0000,
    IT_READ   = 12'b0100_0000_0000,
    IT_NACK   = 12'b1000_0000_0000
  } item_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] device_address;
    logic [7:0] register_index;
    logic [7:0] write_value;
    logic       sda_level;
  } cmd_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        ack_missing;
    logic [15:0] read_result;
    logic        command_rejected;
  } rsp_t;

  typedef struct packed {
    logic [9:0]  half_bit_ticks;
    logic [7:0]  ack_poll_limit;
    logic [9:0]  read_setup_ticks;
    logic [19:0] ranging_wait_ticks;
  } cfg_t;

  function automatic item_t prog_item(input logic [1:0] mode, input logic [3:0] idx);
    item_t it;
    it = IT_IDLE;
    case (idx)
      4'd0: it = IT_START;
      4'd1: it = IT_SADDR;
      4'd2: it = IT_ACK;
      4'd3: it = IT_SREG;
      4'd4: it = IT_ACK;
      4'd5: it = (mode == OP_WRITE || mode == OP_RANGE) ? IT_SDATA : IT_START;
      4'd6: it = (mode == OP_WRITE || mode == OP_RANGE) ? IT_ACK : IT_SRADDR;
      4'd7: it = (mode == OP_WRITE || mode == OP_RANGE) ? IT_STOP : IT_ACK;
      4'd8: it = (mode == OP_RANGE) ? IT_RWAIT : IT_SETUP;
      4'd9: it = IT_READ;
      4'd10: it = IT_NACK;
      4'd11: it = IT_STOP;
      default: it = IT_IDLE;
    endcase
    return it;
  endfunction

  function automatic logic [3:0] prog_len(input logic [1:0] mode);
    logic [3:0] n;
    case (mode)
      OP_WRITE: n = 4'd8;
      OP_RANGE: n = 4'd9;
      default:  n = 4'd12;
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/i2crs_stream_if.sv -----
// ----------------------------------------------------------------------------
// i2crs_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface i2crs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/i2crs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// i2crs_cfg_regs
// Timing configuration registers written through a plain write port.
// ----------------------------------------------------------------------------
module i2crs_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [i2crs_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [i2crs_pkg::CfgDataWidth-1:0]    cfg_data,
  output i2crs_pkg::cfg_t                       cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_bit_ticks     <= 10'(i2crs_pkg::HalfBitReset);
      cfg.ack_poll_limit     <= 8'(i2crs_pkg::AckPollReset);
      cfg.read_setup_ticks   <= 10'(i2crs_pkg::ReadSetupReset);
      cfg.ranging_wait_ticks <= 20'(i2crs_pkg::RangeWaitReset);
    end else if (cfg_we) begin
      case (cfg_index)
        i2crs_pkg::CFG_HALF_BIT:   cfg.half_bit_ticks     <= cfg_data[9:0];
        i2crs_pkg::CFG_ACK_POLL:   cfg.ack_poll_limit     <= cfg_data[7:0];
        i2crs_pkg::CFG_READ_SETUP: cfg.read_setup_ticks   <= cfg_data[9:0];
        i2crs_pkg::CFG_RANGE_WAIT: cfg.ranging_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

// ----- hw/rtl/i2crs_seq.sv -----
// ----------------------------------------------------------------------------
// i2crs_seq
// Bus sequencer: one tick per command, producing the bus levels and status.
// ----------------------------------------------------------------------------
module i2crs_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  i2crs_pkg::cfg_t  cfg,
  input  i2crs_pkg::cmd_t  cmd,
  output i2crs_pkg::rsp_t  rsp
);
  i2crs_pkg::item_t phase, phase_next;
  logic [19:0] tick_count, tick_count_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [3:0]  step_index, step_index_next;
  logic [25:0] latched_command, latched_command_next;
  logic [15:0] result_accumulator, result_accumulator_next;
  logic        error_flag, error_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= i2crs_pkg::IT_IDLE;
      tick_count         <= '0;
      bit_count          <= '0;
      shift_byte         <= '0;
      step_index         <= '0;
      latched_command    <= '0;
      result_accumulator <= '0;
      error_flag         <= 1'b0;
    end else if (step) begin
      phase              <= phase_next;
      tick_count         <= tick_count_next;
      bit_count          <= bit_count_next;
      shift_byte         <= shift_byte_next;
      step_index         <= step_index_next;
      latched_command    <= latched_command_next;
      result_accumulator <= result_accumulator_next;
      error_flag         <= error_flag_next;
    end
  end

  // Step entry is unrolled into at most four passes; a range read needs the
  // most (range wait skipped, first read list, then items).
  always_comb begin
    logic [9:0]  h;
    logic [10:0] h2, hh;
    logic [11:0] h3;
    logic        scl, pull, rej, done, adv, go;
    logic [15:0] res;
    logic [1:0]  mode;
    logic [7:0]  addr, reg_i;
    i2crs_pkg::item_t it;
    phase_next = phase;
    tick_count_next = tick_count;
    bit_count_next = bit_count;
    shift_byte_next = shift_byte;
    step_index_next = step_index;
    latched_command_next = latched_command;
    result_accumulator_next = result_accumulator;
    error_flag_next = error_flag;
    h = (cfg.half_bit_ticks == 10'd0) ? 10'd1 : cfg.half_bit_ticks;
    h2 = {h, 1'b0};
    h3 = 12'(h2) + 12'(h);
    hh = 11'(h) + 11'((11'(h) + 11'd1) >> 1);
    scl = 1'b1;
    pull = 1'b0;
    rej = 1'b0;
    done = 1'b0;
    adv = 1'b0;
    go = 1'b0;
    res = '0;
    mode = '0;
    addr = '0;
    reg_i = '0;
    it = i2crs_pkg::IT_IDLE;

    if (phase != i2crs_pkg::IT_IDLE) begin
      rej = (cmd.op != i2crs_pkg::OP_TICK);
    end else if (cmd.op != i2crs_pkg::OP_TICK) begin
      latched_command_next = {cmd.op, cmd.device_address,
        (cmd.op == i2crs_pkg::OP_RANGE) ? i2crs_pkg::RangeRegHigh : cmd.register_index,
        cmd.write_value};
      error_flag_next = 1'b0;
      result_accumulator_next = '0;
      step_index_next = '0;
      go = 1'b1;
    end

    if (!go) begin
      case (phase_next)
        i2crs_pkg::IT_START: begin
          pull = (tick_count_next >= 20'(h));
          tick_count_next = tick_count_next + 20'd1;
          adv = (tick_count_next >= 20'(h2));
        end
        i2crs_pkg::IT_SADDR, i2crs_pkg::IT_SREG, i2crs_pkg::IT_SDATA,
        i2crs_pkg::IT_SRADDR: begin
          pull = !shift_byte_next[7];
          scl = (tick_count_next >= 20'(h)) && (tick_count_next < 20'(h2));
          tick_count_next = tick_count_next + 20'd1;
          if (tick_count_next >= 20'(h3)) begin
            tick_count_next = '0;
            shift_byte_next = {shift_byte_next[6:0], 1'b0};
            bit_count_next = bit_count_next + 4'd1;
            adv = (bit_count_next >= 4'd8);
          end
        end
        i2crs_pkg::IT_ACK: begin
          if (bit_count_next == 4'd0) begin
            scl = 1'b0;
            tick_count_next = tick_count_next + 20'd1;
            if (tick_count_next >= 20'(h)) begin
              tick_count_next = '0;
              bit_count_next = 4'd1;
            end
          end else if (!cmd.sda_level) begin
            adv = 1'b1;
          end else begin
            tick_count_next = tick_count_next + 20'd1;
            if (tick_count_next > 20'(cfg.ack_poll_limit)) begin
              error_flag_next = 1'b1;
              phase_next = i2crs_pkg::IT_STOP;
              tick_count_next = '0;
              bit_count_next = '0;
            end
          end
        end
        i2crs_pkg::IT_STOP: begin
          scl = (tick_count_next >= 20'(h));
          pull = (tick_count_next < 20'(h2));
          tick_count_next = tick_count_next + 20'd1;
          if (tick_count_next >= 20'(h3)) begin
            if (error_flag_next) begin
              phase_next = i2crs_pkg::IT_IDLE;
              tick_count_next = '0;
              bit_count_next = '0;
              step_index_next = '0;
              done = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
        end
        i2crs_pkg::IT_SETUP: begin
          scl = 1'b0;
          tick_count_next = tick_count_next + 20'd1;
          adv = (tick_count_next >= 20'(cfg.read_setup_ticks));
        end
        i2crs_pkg::IT_RWAIT: begin
          tick_count_next = tick_count_next + 20'd1;
          adv = (tick_count_next >= cfg.ranging_wait_ticks);
        end
        i2crs_pkg::IT_READ: begin
          scl = (tick_count_next >= 20'(h));
          if (tick_count_next == 20'(h))
            shift_byte_next = {shift_byte_next[6:0], cmd.sda_level};
          tick_count_next = tick_count_next + 20'd1;
          if (tick_count_next >= 20'(hh)) begin
            tick_count_next = '0;
            bit_count_next = bit_count_next + 4'd1;
            adv = (bit_count_next >= 4'd8);
          end
        end
        i2crs_pkg::IT_NACK: begin
          scl = (tick_count_next >= 20'(h));
          tick_count_next = tick_count_next + 20'd1;
          adv = (tick_count_next >= 20'(h2));
        end
        default: phase_next = i2crs_pkg::IT_IDLE;
      endcase
      if (adv) step_index_next = step_index_next + 4'd1;
    end

    // Entering a new item; at most four passes resolve it.
    if (go || adv) begin
      for (int p = 0; p < 4; p++) begin
        if (!done && (go || adv)) begin
          mode = latched_command_next[25:24];
          addr = latched_command_next[23:16];
          reg_i = latched_command_next[15:8];
          if (step_index_next >= i2crs_pkg::prog_len(mode)) begin
            if (mode == i2crs_pkg::OP_WRITE || mode == i2crs_pkg::OP_READ ||
                (mode == i2crs_pkg::MODE_RREAD && reg_i != i2crs_pkg::RangeRegHigh)) begin
              if (mode == i2crs_pkg::OP_READ) res = {8'd0, shift_byte_next};
              else if (mode == i2crs_pkg::MODE_RREAD) begin
                result_accumulator_next = {result_accumulator_next[15:8], shift_byte_next};
                res = result_accumulator_next;
              end
              phase_next = i2crs_pkg::IT_IDLE;
              tick_count_next = '0;
              bit_count_next = '0;
              step_index_next = '0;
              done = 1'b1;
            end else begin
              if (mode == i2crs_pkg::MODE_RREAD) begin
                result_accumulator_next = {shift_byte_next, 8'd0};
                latched_command_next[15:8] = i2crs_pkg::RangeRegLow;
              end else begin
                latched_command_next[15:8] = i2crs_pkg::RangeRegHigh;
              end
              latched_command_next[25:24] = i2crs_pkg::MODE_RREAD;
              step_index_next = '0;
            end
          end else begin
            it = i2crs_pkg::prog_item(mode, step_index_next);
            phase_next = it;
            tick_count_next = '0;
            bit_count_next = '0;
            if ((it == i2crs_pkg::IT_SETUP && cfg.read_setup_ticks == 10'd0) ||
                (it == i2crs_pkg::IT_RWAIT && cfg.ranging_wait_ticks == 20'd0)) begin
              step_index_next = step_index_next + 4'd1;
            end else begin
              case (it)
                i2crs_pkg::IT_SADDR:  shift_byte_next = addr;
                i2crs_pkg::IT_SREG:   shift_byte_next = reg_i;
                i2crs_pkg::IT_SDATA:  shift_byte_next = latched_command_next[7:0];
                i2crs_pkg::IT_SRADDR: shift_byte_next = addr + 8'd1;
                i2crs_pkg::IT_READ:   shift_byte_next = '0;
                default: ;
              endcase
              go = 1'b0;
              adv = 1'b0;
            end
          end
        end
      end
    end

    // A freshly started item runs its first tick now.
    if (cmd.op != i2crs_pkg::OP_TICK && phase == i2crs_pkg::IT_IDLE) begin
      // The accepting tick is the first tick of START: SCL high, SDA released.
      tick_count_next = tick_count_next + 20'd1;
    end

    rsp.scl_level = scl;
    rsp.sda_pull_low = pull;
    rsp.busy_res = (phase_next != i2crs_pkg::IT_IDLE);
    rsp.done_res = done;
    rsp.ack_missing = done && error_flag_next;
    rsp.read_result = done ? res : 16'd0;
    rsp.command_rejected = rej;
  end
endmodule

// ----- hw/rtl/i2c_ranging_sensor_master.sv -----
// ----------------------------------------------------------------------------
// i2c_ranging_sensor_master
// I2C master for a ranging sensor, advanced one bus tick per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick and yields exactly one result
// transaction carrying the SCL and SDA levels for that tick and the status.
// The block takes one tick per clock cycle; the sequencer state updates on
// each accepted tick and the result sits in one output register, so the input
// stays ready whenever the output register is empty or being drained.
module i2c_ranging_sensor_master (
  input  logic                                 clk,
  input  logic                                 rst,
  i2crs_stream_if.sink                         cmd_in,
  i2crs_stream_if.source                       rsp_out,
  input  logic                                 cfg_we,
  input  logic [i2crs_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [i2crs_pkg::CfgDataWidth-1:0]   cfg_data
);
  i2crs_pkg::cfg_t cfg;
  i2crs_pkg::rsp_t rsp;
  logic            step;

  assign cmd_in.ready = !rsp_out.valid || rsp_out.ready;
  assign step = cmd_in.valid && cmd_in.ready;

  i2crs_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  i2crs_seq u_seq (
    .clk(clk), .rst(rst), .step(step), .cfg(cfg), .cmd(cmd_in.data), .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_out.valid <= 1'b0;
    end else if (cmd_in.ready) begin
      rsp_out.valid <= cmd_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp_out.data <= rsp;
    end
  end

`ifndef SYNTHESIS
  a_ack_with_done: assert property (@(posedge clk) disable iff (rst)
    rsp_out.valid |-> (!rsp_out.data.ack_missing || rsp_out.data.done_res))
    else $error("ack_missing without done");
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_out.valid |-> !(rsp_out.data.done_res && rsp_out.data.busy_res))
    else $error("done while still busy");
  a_result_on_done: assert property (@(posedge clk) disable iff (rst)
    (rsp_out.valid && !rsp_out.data.done_res) |-> (rsp_out.data.read_result == 16'd0))
    else $error("result without done");
  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    (cmd_in.valid && cmd_in.ready) |=> rsp_out.valid)
    else $error("accepted tick lost");
`endif
endmodule

// ----- dv/i2crs_tb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crs_tb_checker
// Watches the tick and response channels of the I2C ranging sensor master,
// predicts the bus levels and status of every tick and compares each field.
// ----------------------------------------------------------------------------
module i2crs_tb_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  input  logic                                 cmd_ready,
  input  i2crs_pkg::cmd_t                      cmd_data,
  input  logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  input  i2crs_pkg::rsp_t                      rsp_data,
  input  logic                                 cfg_we,
  input  logic [i2crs_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [i2crs_pkg::CfgDataWidth-1:0]   cfg_data,
  output int                                   pending,
  output int                                   failures
);

  logic [9:0]  half_ticks;
  logic [7:0]  poll_limit;
  logic [9:0]  setup_ticks;
  logic [19:0] wait_ticks;

  i2crs_pkg::item_t bus_item;
  int unsigned tick_cnt;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [3:0]  step_idx;
  logic [1:0]  mode;
  logic [7:0]  dev_addr;
  logic [7:0]  reg_idx;
  logic [7:0]  data_byte;
  logic [15:0] distance;
  logic        nack_seen;
  logic        ended;
  logic [15:0] end_value;

  i2crs_pkg::rsp_t expected_ticks[$];

  function automatic i2crs_pkg::item_t bus_sequence(input logic [1:0] m,
                                                    input logic [3:0] i);
    i2crs_pkg::item_t it;
    it = i2crs_pkg::IT_IDLE;
    if (i == 4'd0) it = i2crs_pkg::IT_START;
    else if (i == 4'd1) it = i2crs_pkg::IT_SADDR;
    else if (i == 4'd2 || i == 4'd4) it = i2crs_pkg::IT_ACK;
    else if (i == 4'd3) it = i2crs_pkg::IT_SREG;
    else if (m == i2crs_pkg::OP_WRITE || m == i2crs_pkg::OP_RANGE) begin
      if (i == 4'd5) it = i2crs_pkg::IT_SDATA;
      else if (i == 4'd6) it = i2crs_pkg::IT_ACK;
      else if (i == 4'd7) it = i2crs_pkg::IT_STOP;
      else if (i == 4'd8 && m == i2crs_pkg::OP_RANGE) it = i2crs_pkg::IT_RWAIT;
    end else begin
      if (i == 4'd5) it = i2crs_pkg::IT_START;
      else if (i == 4'd6) it = i2crs_pkg::IT_SRADDR;
      else if (i == 4'd7) it = i2crs_pkg::IT_ACK;
      else if (i == 4'd8) it = i2crs_pkg::IT_SETUP;
      else if (i == 4'd9) it = i2crs_pkg::IT_READ;
      else if (i == 4'd10) it = i2crs_pkg::IT_NACK;
      else if (i == 4'd11) it = i2crs_pkg::IT_STOP;
    end
    return it;
  endfunction

  function automatic void end_transfer(input logic [15:0] value);
    bus_item  = i2crs_pkg::IT_IDLE;
    tick_cnt  = 0;
    bit_cnt   = '0;
    step_idx  = '0;
    ended     = 1'b1;
    end_value = value;
  endfunction

  function automatic void load_step();
    int unsigned      len;
    i2crs_pkg::item_t it;
    bit               stop;
    stop = 0;
    while (!stop) begin
      len = (mode == i2crs_pkg::OP_WRITE) ? 8 : (mode == i2crs_pkg::OP_RANGE) ? 9 : 12;
      if (step_idx >= len) begin
        if (mode == i2crs_pkg::OP_WRITE) begin
          end_transfer(16'h0);
          stop = 1;
        end else if (mode == i2crs_pkg::OP_READ) begin
          end_transfer({8'h0, shreg});
          stop = 1;
        end else if (mode == i2crs_pkg::OP_RANGE) begin
          mode = i2crs_pkg::MODE_RREAD;
          reg_idx = i2crs_pkg::RangeRegHigh;
          step_idx = '0;
        end else if (reg_idx == i2crs_pkg::RangeRegHigh) begin
          distance = {shreg, 8'h0};
          reg_idx = i2crs_pkg::RangeRegLow;
          step_idx = '0;
        end else begin
          distance[7:0] = shreg;
          end_transfer(distance);
          stop = 1;
        end
      end else begin
        it = bus_sequence(mode, step_idx);
        bus_item = it;
        tick_cnt = 0;
        bit_cnt = '0;
        if ((it == i2crs_pkg::IT_SETUP && setup_ticks == 0) ||
            (it == i2crs_pkg::IT_RWAIT && wait_ticks == 0)) begin
          step_idx = step_idx + 4'd1;
        end else begin
          if (it == i2crs_pkg::IT_SADDR) shreg = dev_addr;
          else if (it == i2crs_pkg::IT_SREG) shreg = reg_idx;
          else if (it == i2crs_pkg::IT_SDATA) shreg = data_byte;
          else if (it == i2crs_pkg::IT_SRADDR) shreg = dev_addr + 8'd1;
          else if (it == i2crs_pkg::IT_READ) shreg = 8'h0;
          stop = 1;
        end
      end
    end
  endfunction

  function automatic void next_step();
    step_idx = step_idx + 4'd1;
    load_step();
  endfunction

  function automatic i2crs_pkg::rsp_t bus_tick(input i2crs_pkg::cmd_t c);
    i2crs_pkg::rsp_t r;
    int unsigned     h;
    int unsigned     hh;
    logic            scl;
    logic            pull;
    logic            rej;
    h = (half_ticks == 0) ? 1 : half_ticks;
    scl = 1'b1;
    pull = 1'b0;
    rej = 1'b0;
    ended = 1'b0;
    end_value = 16'h0;
    if (bus_item != i2crs_pkg::IT_IDLE) begin
      if (c.op != i2crs_pkg::OP_TICK) rej = 1'b1;
    end else if (c.op != i2crs_pkg::OP_TICK) begin
      mode = c.op;
      dev_addr = c.device_address;
      reg_idx = (c.op == i2crs_pkg::OP_RANGE) ? i2crs_pkg::RangeRegHigh : c.register_index;
      data_byte = c.write_value;
      nack_seen = 1'b0;
      distance = 16'h0;
      step_idx = '0;
      load_step();
    end
    case (bus_item)
      i2crs_pkg::IT_START: begin
        pull = (tick_cnt >= h);
        tick_cnt++;
        if (tick_cnt >= 2 * h) next_step();
      end
      i2crs_pkg::IT_SADDR, i2crs_pkg::IT_SREG, i2crs_pkg::IT_SDATA,
      i2crs_pkg::IT_SRADDR: begin
        pull = !shreg[7];
        scl = (tick_cnt >= h && tick_cnt < 2 * h);
        tick_cnt++;
        if (tick_cnt >= 3 * h) begin
          tick_cnt = 0;
          shreg = {shreg[6:0], 1'b0};
          bit_cnt++;
          if (bit_cnt >= 8) next_step();
        end
      end
      i2crs_pkg::IT_ACK: begin
        if (bit_cnt == 0) begin
          scl = 1'b0;
          tick_cnt++;
          if (tick_cnt >= h) begin
            tick_cnt = 0;
            bit_cnt = 4'd1;
          end
        end else if (!c.sda_level) begin
          next_step();
        end else begin
          tick_cnt++;
          if (tick_cnt > poll_limit) begin
            nack_seen = 1'b1;
            bus_item = i2crs_pkg::IT_STOP;
            tick_cnt = 0;
            bit_cnt = '0;
          end
        end
      end
      i2crs_pkg::IT_STOP: begin
        scl = (tick_cnt >= h);
        pull = (tick_cnt < 2 * h);
        tick_cnt++;
        if (tick_cnt >= 3 * h) begin
          if (nack_seen) end_transfer(16'h0);
          else next_step();
        end
      end
      i2crs_pkg::IT_SETUP: begin
        scl = 1'b0;
        tick_cnt++;
        if (tick_cnt >= setup_ticks) next_step();
      end
      i2crs_pkg::IT_RWAIT: begin
        tick_cnt++;
        if (tick_cnt >= wait_ticks) next_step();
      end
      i2crs_pkg::IT_READ: begin
        hh = (h + 1) / 2;
        scl = (tick_cnt >= h);
        if (tick_cnt == h) shreg = {shreg[6:0], c.sda_level};
        tick_cnt++;
        if (tick_cnt >= h + hh) begin
          tick_cnt = 0;
          bit_cnt++;
          if (bit_cnt >= 8) next_step();
        end
      end
      i2crs_pkg::IT_NACK: begin
        scl = (tick_cnt >= h);
        tick_cnt++;
        if (tick_cnt >= 2 * h) next_step();
      end
      default: bus_item = i2crs_pkg::IT_IDLE;
    endcase
    r.scl_level = scl;
    r.sda_pull_low = pull;
    r.busy_res = (bus_item != i2crs_pkg::IT_IDLE);
    r.done_res = ended;
    r.ack_missing = ended && nack_seen;
    r.read_result = ended ? end_value : 16'h0;
    r.command_rejected = rej;
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    i2crs_pkg::rsp_t exp_r;
    if (rst) begin
      half_ticks = 10'(i2crs_pkg::HalfBitReset);
      poll_limit = 8'(i2crs_pkg::AckPollReset);
      setup_ticks = 10'(i2crs_pkg::ReadSetupReset);
      wait_ticks = 20'(i2crs_pkg::RangeWaitReset);
      bus_item = i2crs_pkg::IT_IDLE;
      tick_cnt = 0;
      bit_cnt = '0;
      shreg = '0;
      step_idx = '0;
      mode = '0;
      dev_addr = '0;
      reg_idx = '0;
      data_byte = '0;
      distance = '0;
      nack_seen = 1'b0;
      expected_ticks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          i2crs_pkg::CFG_HALF_BIT:   half_ticks = cfg_data[9:0];
          i2crs_pkg::CFG_ACK_POLL:   poll_limit = cfg_data[7:0];
          i2crs_pkg::CFG_READ_SETUP: setup_ticks = cfg_data[9:0];
          i2crs_pkg::CFG_RANGE_WAIT: wait_ticks = cfg_data;
          default: ;
        endcase
      end
      if (cmd_valid && cmd_ready) expected_ticks.push_back(bus_tick(cmd_data));
      if (rsp_valid && rsp_ready) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %0h", $time, rsp_data);
          failures++;
        end else begin
          exp_r = expected_ticks.pop_front();
          check_field("scl_level", exp_r.scl_level, rsp_data.scl_level);
          check_field("sda_pull_low", exp_r.sda_pull_low, rsp_data.sda_pull_low);
          check_field("busy_res", exp_r.busy_res, rsp_data.busy_res);
          check_field("done_res", exp_r.done_res, rsp_data.done_res);
          check_field("ack_missing", exp_r.ack_missing, rsp_data.ack_missing);
          check_field("read_result", exp_r.read_result, rsp_data.read_result);
          check_field("command_rejected", exp_r.command_rejected, rsp_data.command_rejected);
        end
      end
    end
    pending = expected_ticks.size();
  end

  initial begin
    failures = 0;
    pending = 0;
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the I2C ranging sensor master: directed transactions and
// random ticks with emulated SDA under several timing settings and stalls.
// ----------------------------------------------------------------------------
module tb;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [i2crs_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [i2crs_pkg::CfgDataWidth-1:0]  cfg_data;
  int pending;
  int failures;
  int send_idle;
  int recv_idle;
  int hold_req;
  int sda_high_run;
  logic last_busy;
  int n_done;
  int n_abort;
  int n_reject;
  int n_rsp;

  i2crs_stream_if #(.payload_t(i2crs_pkg::cmd_t)) cmd_if ();
  i2crs_stream_if #(.payload_t(i2crs_pkg::rsp_t)) rsp_if ();

  i2c_ranging_sensor_master DUT (
    .clk(clk),
    .rst(rst),
    .cmd_in(cmd_if.sink),
    .rsp_out(rsp_if.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  i2crs_tb_checker checker_i (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_if.valid),
    .cmd_ready(cmd_if.ready),
    .cmd_data(cmd_if.data),
    .rsp_valid(rsp_if.valid),
    .rsp_ready(rsp_if.ready),
    .rsp_data(rsp_if.data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pending(pending),
    .failures(failures)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      last_busy <= rsp_if.data.busy_res;
      n_rsp <= n_rsp + 1;
      if (rsp_if.data.done_res) n_done <= n_done + 1;
      if (rsp_if.data.ack_missing) n_abort <= n_abort + 1;
      if (rsp_if.data.command_rejected) n_reject <= n_reject + 1;
    end
  end

  initial begin
    int hold;
    hold = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        rsp_if.ready = 1'b0;
        hold--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_tick(input logic [1:0] op, input logic [7:0] addr,
                           input logic [7:0] regi, input logic [7:0] val, input logic sda);
    while ($urandom_range(99) < send_idle) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.valid = 1'b1;
    cmd_if.data = '{op: op, device_address: addr, register_index: regi,
                    write_value: val, sda_level: sda};
    do @(posedge clk); while (!cmd_if.ready);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [1:0] op;
    logic       sda;
    op = i2crs_pkg::OP_TICK;
    if ((!last_busy && $urandom_range(99) < 50) || $urandom_range(99) < 3)
      op = 2'($urandom_range(3));
    if (sda_high_run > 0) begin
      sda = 1'b1;
      sda_high_run--;
    end else begin
      sda = ($urandom_range(99) < 30);
      if ($urandom_range(99) < 2) sda_high_run = $urandom_range(12);
    end
    send_tick(op, 8'($urandom), 8'($urandom), 8'($urandom), sda);
  endtask

  task automatic settle();
    forever begin
      cmd_if.valid = 1'b0;
      while (pending != 0) @(negedge clk);
      if (!last_busy) break;
      send_tick(i2crs_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
    end
    cmd_if.valid = 1'b0;
    repeat (3) @(negedge clk);
  endtask

  task automatic set_timing(input logic [19:0] hb, input logic [19:0] poll,
                            input logic [19:0] setup, input logic [19:0] rwait);
    cfg_we = 1'b1;
    cfg_index = i2crs_pkg::CFG_HALF_BIT;
    cfg_data = hb;
    @(negedge clk);
    cfg_index = i2crs_pkg::CFG_ACK_POLL;
    cfg_data = poll;
    @(negedge clk);
    cfg_index = i2crs_pkg::CFG_READ_SETUP;
    cfg_data = setup;
    @(negedge clk);
    cfg_index = i2crs_pkg::CFG_RANGE_WAIT;
    cfg_data = rwait;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random();
    cmd_if.valid = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    send_idle = 0;
    recv_idle = 0;
    hold_req = 0;
    sda_high_run = 0;
    last_busy = 1'b0;
    n_done = 0;
    n_abort = 0;
    n_reject = 0;
    n_rsp = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    set_timing(20'd0, 20'd0, 20'd0, 20'd0);
    send_tick(i2crs_pkg::OP_WRITE, 8'h00, 8'hFF, 8'h00, 1'b1);
    repeat (12) send_tick(i2crs_pkg::OP_TICK, 8'hFF, 8'h00, 8'hFF, 1'b1);
    settle();
    send_tick(i2crs_pkg::OP_READ, 8'hFF, 8'h00, 8'hFF, 1'b0);
    send_tick(i2crs_pkg::OP_RANGE, 8'h00, 8'hFF, 8'h00, 1'b0);
    send_tick(i2crs_pkg::OP_WRITE, 8'h55, 8'hAA, 8'h0F, 1'b1);
    settle();

    set_timing(20'd2, 20'd255, 20'd3, 20'd1);
    send_idle = 12;
    recv_idle = 51;
    run_random(60);
    settle();

    set_timing(20'd1, 20'd2, 20'd1, 20'd17);
    send_idle = 51;
    recv_idle = 12;
    hold_req = 60;
    run_random(60);
    settle();

    set_timing(20'd1, 20'd5, 20'd0, 20'd0);
    send_idle = 0;
    recv_idle = 0;
    run_random(60);
    settle();

    set_timing(20'd1023, 20'd255, 20'd1023, 20'hFFFFF);
    send_tick(i2crs_pkg::OP_RANGE, 8'h3C, 8'h00, 8'hC3, 1'b0);
    repeat (40) send_tick(i2crs_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
    cmd_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    $display("Checked %0d ticks under five timing settings, including idle and stall patterns.",
             n_rsp);
    $display("Transfers ended: %0d, aborted on missing ACK: %0d, commands rejected: %0d.",
             n_done, n_abort, n_reject);
    if (failures == 0) begin
      $display("i2c_ranging_sensor_master regression: pass");
    end else begin
      $display("i2c_ranging_sensor_master regression: fail");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("i2c_ranging_sensor_master regression: fail");
    $finish;
  end

endmodule
